// ----- src/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the streaming string replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned REG_SEL_LSB = 3;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES = 2'd0,
    REG_PATTERN_LEN   = 2'd1,
    REG_REPLACE_BYTES = 2'd2,
    REG_REPLACE_LEN   = 2'd3
  } reg_sel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_done;
  } out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              eos;
    logic              is_newline;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [LEN_W-1:0]  pattern_len;
    logic [WORD_W-1:0] replace;
    logic [LEN_W-1:0]  replace_len;
  } cfg_t;

endpackage

// ----- src/ssr_cfg.sv -----
// ----------------------------------------------------------------------------
// ssr_cfg
// Register file on the APB-style port. Holds pattern and replacement and
// presents the lengths already limited to what the datapath supports.
// ----------------------------------------------------------------------------
module ssr_cfg #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssr_pkg::WORD_W-1:0]  pwdata,
  output logic [ssr_pkg::WORD_W-1:0]  prdata,
  output logic                        pready,
  output ssr_pkg::cfg_t               cfg
);
  import ssr_pkg::*;

  reg_sel_t          sel;
  logic              wr;
  logic [WORD_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  pattern_len;
  logic [WORD_W-1:0] replace_bytes;
  logic [LEN_W-1:0]  replace_len;
  logic [LEN_W-1:0]  plen_eff;
  logic [LEN_W-1:0]  rlen_eff;

  assign sel    = reg_sel_t'(paddr[ADDR_W-1:REG_SEL_LSB]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes <= '0;
      pattern_len   <= LEN_W'(1);
      replace_bytes <= '0;
      replace_len   <= '0;
    end else if (wr) begin
      case (sel)
        REG_PATTERN_BYTES: pattern_bytes <= pwdata;
        REG_PATTERN_LEN:   pattern_len   <= pwdata[LEN_W-1:0];
        REG_REPLACE_BYTES: replace_bytes <= pwdata;
        REG_REPLACE_LEN:   replace_len   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PATTERN_BYTES: prdata = pattern_bytes;
      REG_PATTERN_LEN:   prdata = WORD_W'(pattern_len);
      REG_REPLACE_BYTES: prdata = replace_bytes;
      REG_REPLACE_LEN:   prdata = WORD_W'(replace_len);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (pattern_len == '0) begin
      plen_eff = LEN_W'(1);
    end else if (pattern_len > LEN_W'(PATTERN_MAX)) begin
      plen_eff = LEN_W'(PATTERN_MAX);
    end else begin
      plen_eff = pattern_len;
    end
    if (replace_len > LEN_W'(REPLACE_MAX)) begin
      rlen_eff = LEN_W'(REPLACE_MAX);
    end else begin
      rlen_eff = replace_len;
    end
  end

  assign cfg = '{pattern: pattern_bytes, pattern_len: plen_eff,
                 replace: replace_bytes, replace_len: rlen_eff};

endmodule

// ----- src/ssr_front.sv -----
// ----------------------------------------------------------------------------
// ssr_front
// Accepts input bytes, marks newlines and queues them in a two-entry queue
// ahead of the replace engine.
// ----------------------------------------------------------------------------
module ssr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ssr_pkg::in_t   in_data,
  output logic           q_valid,
  output ssr_pkg::item_t q_item,
  input  logic           q_pop
);
  import ssr_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  item_t       new_item;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];

  assign new_item = '{byte_val: in_data.in_byte, eos: in_data.end_of_stream,
                      is_newline: (in_data.in_byte == NEWLINE_BYTE)};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= new_item;
    end
  end

endmodule

// ----- src/ssr_back.sv -----
// ----------------------------------------------------------------------------
// ssr_back
// Replace engine. Holds the bytes that may still start a match, checks them
// against the pattern and emits held, replacement and newline bytes one per
// cycle while the output does not stall. The newest byte waits in a pending
// register until it is known whether it is the last one caused by its input.
// ----------------------------------------------------------------------------
module ssr_back #(
  parameter int unsigned PATTERN_MAX = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  ssr_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  ssr_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output ssr_pkg::out_t  out_data
);
  import ssr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned HOLD_W = PATTERN_MAX * BYTE_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_REPL  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_TAIL  = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [HOLD_W-1:0]   held;
  logic [CNT_W-1:0]    held_count;
  logic [BYTE_W-1:0]   cur_byte;
  logic                cur_eos;
  logic [LEN_W-1:0]    ridx;
  logic [LEN_W-1:0]    ridx_plus;
  logic                pend_valid;
  logic [BYTE_W-1:0]   pend_byte;

  logic [PATTERN_MAX-1:0] match_ok;
  logic [LEN_W-1:0]    count_ext;
  logic                is_prefix;
  logic                full_match;
  logic                out_free;
  logic                adv_ok;
  logic [BYTE_W-1:0]   repl_byte;

  logic                push;
  logic                shift;
  logic                clear;
  logic                produce;
  logic                finish;
  logic                ridx_inc;
  logic [BYTE_W-1:0]   prod_byte;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      match_ok[i] = (CNT_W'(i) >= held_count) ||
                    (held[i*BYTE_W +: BYTE_W] == cfg.pattern[i*BYTE_W +: BYTE_W]);
    end
  end

  assign count_ext  = LEN_W'(held_count);
  assign is_prefix  = (count_ext <= cfg.pattern_len) && (&match_ok);
  assign full_match = (count_ext == cfg.pattern_len);
  assign out_free   = !out_valid || !out_stall;
  assign adv_ok     = !pend_valid || out_free;
  assign ridx_plus  = ridx + LEN_W'(1);
  assign repl_byte  = cfg.replace[{ridx[2:0], 3'b000} +: BYTE_W];

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    push       = 1'b0;
    shift      = 1'b0;
    clear      = 1'b0;
    produce    = 1'b0;
    finish     = 1'b0;
    ridx_inc   = 1'b0;
    prod_byte  = held[BYTE_W-1:0];
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.is_newline) begin
            state_next = ST_FLUSH;
          end else begin
            push       = 1'b1;
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (is_prefix) begin
          if (full_match) begin
            clear      = 1'b1;
            state_next = (cfg.replace_len != '0) ? ST_REPL : ST_TAIL;
          end else if (!cur_eos && adv_ok) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_TAIL;
          end
        end else if (adv_ok) begin
          produce = 1'b1;
          shift   = 1'b1;
        end
      end
      ST_REPL: begin
        if (adv_ok) begin
          produce   = 1'b1;
          prod_byte = repl_byte;
          ridx_inc  = 1'b1;
          if (ridx_plus == cfg.replace_len) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_FLUSH: begin
        if (adv_ok) begin
          produce = 1'b1;
          if (held_count != '0) begin
            shift = 1'b1;
          end else begin
            prod_byte  = cur_byte;
            state_next = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (adv_ok) begin
          if (cur_eos && (held_count != '0)) begin
            produce = 1'b1;
            shift   = 1'b1;
          end else begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      ridx       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        held_count <= held_count + CNT_W'(1);
      end else if (clear) begin
        held_count <= '0;
      end else if (shift) begin
        held_count <= held_count - CNT_W'(1);
      end
      if (clear) begin
        ridx <= '0;
      end else if (ridx_inc) begin
        ridx <= ridx_plus;
      end
      if (produce) begin
        pend_valid <= 1'b1;
      end else if (finish) begin
        pend_valid <= 1'b0;
      end
      if ((produce || finish) && pend_valid) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held[held_count*BYTE_W +: BYTE_W] <= q_item.byte_val;
    end else if (shift) begin
      held <= held >> BYTE_W;
    end
    if (q_pop) begin
      cur_byte <= q_item.byte_val;
      cur_eos  <= q_item.eos;
    end
    if (produce) begin
      pend_byte <= prod_byte;
    end
    if ((produce || finish) && pend_valid) begin
      out_data <= '{out_byte: pend_byte, last_of_run: finish,
                    stream_done: finish && cur_eos};
    end
  end

endmodule

// ----- src/streaming_string_replace.sv -----
// ----------------------------------------------------------------------------
// streaming_string_replace
// A byte that passes straight through goes from the queue to the held bytes,
// the pending register and the output register. The engine takes no new byte
// before it is through with the last, ends a match, newline or end of stream
// in a tail state and waits on output stalls. Reset clears the held bytes, the
// queue and the output, and sets pattern length one and an empty replacement.
// ----------------------------------------------------------------------------
module streaming_string_replace #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ssr_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ssr_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  logic [ssr_pkg::WORD_W-1:0] pwdata,
  output logic [ssr_pkg::WORD_W-1:0] prdata,
  output logic                       pready
);
  import ssr_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  ssr_cfg #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ssr_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("Engine took an item from an empty queue.");

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> q_valid)
    else $error("Accepted input transfer is missing from the queue.");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stream_done |-> out_data.last_of_run)
    else $error("End of stream marked on a byte that is not last of its run.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid right after reset.");
`endif

endmodule
